[src/tbpf_pkg.sv]
// ----------------------------------------------------------------------------
// tbpf_pkg
// shared codes and pipeline stage types for the tiled background pixel fetch
// ----------------------------------------------------------------------------
package tbpf_pkg;

    localparam int PAL_AW = 8;
    localparam int RGB_W  = 15;

    typedef enum logic [1:0] {
        FUNC_VRAM_WR = 2'd0,
        FUNC_PAL_WR  = 2'd1,
        FUNC_RENDER  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        CFG_LAYER_ENABLE   = 3'd0,
        CFG_SCROLL_X       = 3'd1,
        CFG_SCROLL_Y       = 3'd2,
        CFG_MAP_BASE       = 3'd3,
        CFG_TILE_BASE      = 3'd4,
        CFG_SCREEN_SIZE    = 3'd5,
        CFG_COLOR_DEPTH    = 3'd6,
        CFG_LAYER_PRIORITY = 3'd7
    } t_cfg_idx;

    // after the map read is issued
    typedef struct packed {
        t_func              func;
        logic               vis_pre;
        logic [2:0]         h_lo;
        logic [2:0]         v_lo;
        logic [PAL_AW-1:0]  pal_addr;
        logic [RGB_W-1:0]   pal_data;
    } t_stage1;

    // after the character read is issued
    typedef struct packed {
        t_func              func;
        logic               vis_pre;
        logic [3:0]         bank;
        logic               nib_hi;
        logic               byte_hi;
        logic [PAL_AW-1:0]  pal_addr;
        logic [RGB_W-1:0]   pal_data;
    } t_stage2;

endpackage

[src/tbpf_vram.sv]
// ----------------------------------------------------------------------------
// tbpf_vram
// video memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tbpf_vram #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re_a,
    input  logic [AW-1:0] i_raddr_a,
    output logic [15:0]   o_rdata_a,
    input  logic          i_re_b,
    input  logic [AW-1:0] i_raddr_b,
    output logic [15:0]   o_rdata_b
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata_a;
    logic [15:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[src/tbpf_pal.sv]
// ----------------------------------------------------------------------------
// tbpf_pal
// palette memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tbpf_pal
    import tbpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PAL_AW-1:0] i_waddr,
    input  logic [RGB_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [PAL_AW-1:0] i_raddr,
    output logic [RGB_W-1:0]  o_rdata
);

    logic [RGB_W-1:0] r_mem [2**PAL_AW];
    logic [RGB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tiled_background_pixel_fetch.sv]
// ----------------------------------------------------------------------------
// tiled_background_pixel_fetch
// text-mode tile map background layer, one pixel per render request
// ----------------------------------------------------------------------------
// The block takes one request per clock unless a stalled result backs up all
// stages, and presents the pixel of a render request from registers: the map
// entry read is issued at acceptance, then the character read and the palette
// read follow, each a registered memory read, the two video reads using the
// two read ports of the video memory. Video writes land at acceptance, palette
// writes at the palette read stage, so every request sees exactly the writes
// that came before it. Stages collapse bubbles, so a stalled result holds
// back input only once all stages are full. Memories come up undefined and
// need no clearing pass after reset.
module tiled_background_pixel_fetch
    import tbpf_pkg::*;
#(
    parameter int VRAM_HALFWORDS = 65536,
    parameter int SCREEN_WIDTH   = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // addr, wdata, line, xpos
    input  logic [1:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // visible, rgb, prio, zero pad
);

    localparam int VA = $clog2(VRAM_HALFWORDS);
    localparam logic [16:0] VDEPTH = 17'(VRAM_HALFWORDS);
    localparam logic [9:0]  SWIDTH = 10'(SCREEN_WIDTH);

    function automatic logic [VA-1:0] f_vidx(input logic [15:0] a);
        logic [16:0] t;
        t = {1'b0, a};
        for (int k = 0; k < 3; k++) begin
            if (t >= VDEPTH) begin
                t = t - VDEPTH;
            end
        end
        return t[VA-1:0];
    endfunction

    // configuration
    logic       r_enable;
    logic [8:0] r_scroll_x;
    logic [8:0] r_scroll_y;
    logic [4:0] r_map_base;
    logic [1:0] r_tile_base;
    logic [1:0] r_screen_size;
    logic       r_color_depth;
    logic [1:0] r_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_scroll_x    <= '0;
            r_scroll_y    <= '0;
            r_map_base    <= '0;
            r_tile_base   <= '0;
            r_screen_size <= '0;
            r_color_depth <= 1'b0;
            r_prio        <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_LAYER_ENABLE:   r_enable      <= i_cfg_wdata[0];
                CFG_SCROLL_X:       r_scroll_x    <= i_cfg_wdata;
                CFG_SCROLL_Y:       r_scroll_y    <= i_cfg_wdata;
                CFG_MAP_BASE:       r_map_base    <= i_cfg_wdata[4:0];
                CFG_TILE_BASE:      r_tile_base   <= i_cfg_wdata[1:0];
                CFG_SCREEN_SIZE:    r_screen_size <= i_cfg_wdata[1:0];
                CFG_COLOR_DEPTH:    r_color_depth <= i_cfg_wdata[0];
                CFG_LAYER_PRIORITY: r_prio        <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // request fields
    t_func       w_func;
    logic [15:0] w_addr;
    logic [15:0] w_wdata;
    logic [7:0]  w_line;
    logic [7:0]  w_xpos;

    assign w_func  = t_func'(s_axis_tuser);
    assign w_addr  = s_axis_tdata[15:0];
    assign w_wdata = s_axis_tdata[31:16];
    assign w_line  = s_axis_tdata[39:32];
    assign w_xpos  = s_axis_tdata[47:40];

    // stage control
    logic    r_v1, r_v2, r_v3;
    t_stage1 r_s1;
    t_stage2 r_s2;
    logic    r_vis3;
    logic [1:0] r_prio3;
    logic    w_e1, w_e2, w_e3, w_acc;

    assign w_e3  = !r_v3 || m_axis_tready;
    assign w_e2  = !r_v2 || w_e3;
    assign w_e1  = !r_v1 || w_e2;
    assign w_acc = s_axis_tvalid && w_e1;
    assign s_axis_tready = w_e1;

    // map address
    logic [8:0]  w_h, w_v;
    logic [11:0] w_entry;
    logic [15:0] w_map_hw;

    always_comb begin
        w_h = r_scroll_x + {1'b0, w_xpos};
        w_v = r_scroll_y + {1'b0, w_line};
        w_entry = {2'b00, w_v[7:3], w_h[7:3]};
        if (r_screen_size[0] && w_h[8]) begin
            w_entry = w_entry + 12'd1024;
        end
        if (r_screen_size[1] && w_v[8]) begin
            w_entry = w_entry + (r_screen_size[0] ? 12'd2048 : 12'd1024);
        end
        w_map_hw = {1'b0, r_map_base, 10'b0} + {4'b0, w_entry};
    end

    // character address
    logic [15:0] w_map_q;
    logic [2:0]  w_col, w_row;
    logic [16:0] w_chr_off, w_cb;

    always_comb begin
        w_col = r_s1.h_lo ^ {3{w_map_q[10]}};
        w_row = r_s1.v_lo ^ {3{w_map_q[11]}};
        if (r_color_depth) begin
            w_chr_off = {1'b0, w_map_q[9:0], w_row, w_col};
        end else begin
            w_chr_off = {2'b00, w_map_q[9:0], w_row, w_col[2:1]};
        end
        w_cb = {1'b0, r_tile_base, 14'b0} + w_chr_off;
    end

    // pixel colour
    logic [15:0] w_chr_q;
    logic [7:0]  w_byte, w_color, w_pal_idx;

    always_comb begin
        w_byte = r_s2.byte_hi ? w_chr_q[15:8] : w_chr_q[7:0];
        if (r_color_depth) begin
            w_color   = w_byte;
            w_pal_idx = w_byte;
        end else begin
            w_color   = {4'b0, r_s2.nib_hi ? w_byte[7:4] : w_byte[3:0]};
            w_pal_idx = {r_s2.bank, w_color[3:0]};
        end
    end

    logic w_render2;
    assign w_render2 = r_v2 && (r_s2.func == FUNC_RENDER);

    tbpf_vram #(
        .DEPTH(VRAM_HALFWORDS)
    ) u_vram (
        .i_clk     (i_clk),
        .i_we      (w_acc && (w_func == FUNC_VRAM_WR)),
        .i_waddr   (f_vidx(w_addr)),
        .i_wdata   (w_wdata),
        .i_re_a    (w_acc),
        .i_raddr_a (f_vidx(w_map_hw)),
        .o_rdata_a (w_map_q),
        .i_re_b    (w_e2 && r_v1),
        .i_raddr_b (f_vidx(w_cb[16:1])),
        .o_rdata_b (w_chr_q)
    );

    logic [RGB_W-1:0] w_pal_q;

    tbpf_pal u_pal (
        .i_clk   (i_clk),
        .i_we    (w_e3 && r_v2 && (r_s2.func == FUNC_PAL_WR)),
        .i_waddr (r_s2.pal_addr),
        .i_wdata (r_s2.pal_data),
        .i_re    (w_e3 && w_render2),
        .i_raddr (w_pal_idx),
        .o_rdata (w_pal_q)
    );

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_e1) begin
                r_v1 <= w_acc;
            end
            if (w_e2) begin
                r_v2 <= r_v1;
            end
            if (w_e3) begin
                r_v3 <= w_render2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1.func     <= w_func;
            r_s1.vis_pre  <= r_enable && ({2'b00, w_xpos} < SWIDTH);
            r_s1.h_lo     <= w_h[2:0];
            r_s1.v_lo     <= w_v[2:0];
            r_s1.pal_addr <= w_addr[PAL_AW-1:0];
            r_s1.pal_data <= w_wdata[RGB_W-1:0];
        end
        if (w_e2 && r_v1) begin
            r_s2.func     <= r_s1.func;
            r_s2.vis_pre  <= r_s1.vis_pre;
            r_s2.bank     <= w_map_q[15:12];
            r_s2.nib_hi   <= w_col[0];
            r_s2.byte_hi  <= w_cb[0];
            r_s2.pal_addr <= r_s1.pal_addr;
            r_s2.pal_data <= r_s1.pal_data;
        end
        if (w_e3 && w_render2) begin
            r_vis3  <= r_s2.vis_pre && (w_color != 8'd0);
            r_prio3 <= r_prio;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {6'b0,
                            r_vis3 ? r_prio3 : 2'b00,
                            r_vis3 ? w_pal_q : {RGB_W{1'b0}},
                            r_vis3};

`ifndef ASSERT_OFF
    a_ready_low_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input held back while a stage is empty");

    a_prio_cfg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[17:16] == r_prio))
        else $error("visible pixel priority differs from layer priority");

    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !w_render2) |=> !m_axis_tvalid)
        else $error("result appeared without a render request");
`endif

endmodule

[sim/tiled_background_pixel_fetch_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_background_pixel_fetch_tb
// self-checking bench for the tile map background pixel fetch
// ----------------------------------------------------------------------------
// Loads video memory and palette through the request stream and renders
// pixels under several register settings. A behavioral pixel model in the
// bench predicts every rendered pixel at request acceptance, and the results
// are compared in order. Before each render, any map, character or palette
// entry the model would read is written first, so no unwritten entry shows.
// The request side idles in random bursts, the result side stalls in random
// patterns and once holds off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module tiled_background_pixel_fetch_tb;
    import tbpf_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int SCREEN_W        = 240;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 194;
    localparam int HOLD_CYCLES     = 150;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_DIR           = 22;
    localparam int MAX_REPORTS     = 30;
    localparam longint TIMEOUT_NS  = 64'd20_000_000;

    typedef struct packed {
        logic        visible;
        logic [14:0] rgb;
        logic [1:0]  prio;
    } pixel_t;

    typedef logic [7:0][8:0] cfg_set_t;

    typedef struct {
        int          preset;
        logic [1:0]  func;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [7:0]  scanline;
        logic [7:0]  xpos;
        bit          blank;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // addr, wdata, line, xpos
    logic [1:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // visible, rgb, prio, zero pad

    tiled_background_pixel_fetch uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // pixel model state
    bit [15:0] vmem [65536];
    bit        vwritten [65536];
    bit [14:0] palm [256];
    bit        pwritten [256];
    bit        lay_en;
    bit [8:0]  scr_x, scr_y;
    bit [4:0]  map_blk;
    bit [1:0]  chr_blk, scr_size, lay_prio;
    bit        depth8;

    pixel_t pixel_q [$];

    int  n_err, n_req, n_render, n_vram_wr, n_pal_wr, n_settings;
    int  n_checked, n_visible;
    int  burst_left;
    bit  hold_req;

    dir_row_t dir_rows [N_DIR] = '{
        '{0, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd0,   1'b1},
        '{0, FUNC_RENDER,  16'hFFFF, 16'hFFFF, 8'd255, 8'd239, 1'b1},
        '{0, FUNC_PAL_WR,  16'h01FF, 16'hFFFF, 8'd0,   8'd0,   1'b0},
        '{0, FUNC_VRAM_WR, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b0},
        '{0, FUNC_IGNORED, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b0},
        '{0, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd255, 1'b1},
        '{1, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{1, FUNC_RENDER,  16'hFFFF, 16'hFFFF, 8'd255, 8'd239, 1'b0},
        '{1, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd239, 1'b0},
        '{1, FUNC_RENDER,  16'h0000, 16'h0000, 8'd255, 8'd0,   1'b0},
        '{1, FUNC_RENDER,  16'h0000, 16'h0000, 8'd255, 8'd240, 1'b1},
        '{1, FUNC_PAL_WR,  16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{1, FUNC_IGNORED, 16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{1, FUNC_RENDER,  16'h0000, 16'h0000, 8'd128, 8'd77,  1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd1,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd7,   8'd7,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd8,   8'd8,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd100, 8'd239, 1'b0},
        '{2, FUNC_VRAM_WR, 16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd0,   1'b0},
        '{2, FUNC_RENDER,  16'h0000, 16'h0000, 8'd0,   8'd255, 1'b1}
    };

    function automatic cfg_set_t make_cfg(input logic [8:0] en, sx, sy, mb, tb, ss, cd, pr);
        cfg_set_t c;
        c[CFG_LAYER_ENABLE]   = en;
        c[CFG_SCROLL_X]       = sx;
        c[CFG_SCROLL_Y]       = sy;
        c[CFG_MAP_BASE]       = mb;
        c[CFG_TILE_BASE]      = tb;
        c[CFG_SCREEN_SIZE]    = ss;
        c[CFG_COLOR_DEPTH]    = cd;
        c[CFG_LAYER_PRIORITY] = pr;
        return c;
    endfunction

    // map entry, character halfword and palette index a pixel reads
    function automatic void locate_fetch(input logic [7:0] scanline, xpos,
                                         output logic [15:0] map_hw, chr_hw,
                                         output logic [7:0] pal_idx, color);
        int          h, v, tx, ty, entry, maddr, baddr;
        logic [15:0] map_ent, half;
        logic [2:0]  col, row;
        logic [7:0]  byte_v;
        h  = (int'(scr_x) + int'(xpos)) & 511;
        v  = (int'(scanline) + int'(scr_y)) & 511;
        tx = h >> 3;
        ty = v >> 3;
        entry = (ty & 31) * 32 + (tx & 31);
        if (scr_size[0] && (tx & 32) != 0)
            entry += 1024;
        if (scr_size[1] && (ty & 32) != 0)
            entry += scr_size[0] ? 2048 : 1024;
        maddr   = ((int'(map_blk) << 11) + entry * 2) & 'h1FFFF;
        map_hw  = 16'(maddr >> 1);
        map_ent = vmem[map_hw];
        col = h[2:0] ^ {3{map_ent[10]}};
        row = v[2:0] ^ {3{map_ent[11]}};
        if (!depth8)
            baddr = (int'(chr_blk) << 14) + int'(map_ent[9:0]) * 32 + int'(row) * 4
                    + int'(col >> 1);
        else
            baddr = (int'(chr_blk) << 14) + int'(map_ent[9:0]) * 64 + int'(row) * 8
                    + int'(col);
        baddr  = baddr & 'h1FFFF;
        chr_hw = 16'(baddr >> 1);
        half   = vmem[chr_hw];
        byte_v = baddr[0] ? half[15:8] : half[7:0];
        if (!depth8) begin
            color   = {4'd0, col[0] ? byte_v[7:4] : byte_v[3:0]};
            pal_idx = {map_ent[15:12], color[3:0]};
        end else begin
            color   = byte_v;
            pal_idx = byte_v;
        end
    endfunction

    function automatic pixel_t predict_pixel(input logic [7:0] scanline, xpos);
        pixel_t      px;
        logic [15:0] mh, ch;
        logic [7:0]  pi, color;
        px = '0;
        if (lay_en && xpos < SCREEN_W) begin
            locate_fetch(scanline, xpos, mh, ch, pi, color);
            if (color != 0) begin
                px.visible = 1'b1;
                px.rgb     = palm[pi];
                px.prio    = lay_prio;
            end
        end
        return px;
    endfunction

    task automatic set_reg(input t_cfg_idx idx, input logic [8:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LAYER_ENABLE:   lay_en   = val[0];
            CFG_SCROLL_X:       scr_x    = val;
            CFG_SCROLL_Y:       scr_y    = val;
            CFG_MAP_BASE:       map_blk  = val[4:0];
            CFG_TILE_BASE:      chr_blk  = val[1:0];
            CFG_SCREEN_SIZE:    scr_size = val[1:0];
            CFG_COLOR_DEPTH:    depth8   = val[0];
            CFG_LAYER_PRIORITY: lay_prio = val[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input cfg_set_t c);
        for (int i = 0; i < 8; i++)
            set_reg(t_cfg_idx'(i), c[i]);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // stop offering requests and let every outstanding pixel come back
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] func, input logic [15:0] addr, wdata,
                             input logic [7:0] scanline, xpos, input bit blank);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {xpos, scanline, wdata, addr};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        case (func)
            FUNC_VRAM_WR: begin
                vmem[addr]     = wdata;
                vwritten[addr] = 1'b1;
                n_vram_wr++;
            end
            FUNC_PAL_WR: begin
                palm[addr[7:0]]     = wdata[14:0];
                pwritten[addr[7:0]] = 1'b1;
                n_pal_wr++;
            end
            FUNC_RENDER: begin
                pixel_q.push_back(blank ? pixel_t'('0) : predict_pixel(scanline, xpos));
                n_render++;
            end
            default: ;
        endcase
        if (func != FUNC_IGNORED)
            n_req++;
    endtask

    // fill whatever the pixel would read, then render it
    task automatic render_req(input logic [7:0] scanline, xpos, input logic [15:0] addr, wdata);
        logic [15:0] mh, ch;
        logic [7:0]  pi, color;
        bit          ready;
        ready = !(lay_en && xpos < SCREEN_W);
        while (!ready) begin
            locate_fetch(scanline, xpos, mh, ch, pi, color);
            if (!vwritten[mh])
                send_item(FUNC_VRAM_WR, mh, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            else if (!vwritten[ch])
                send_item(FUNC_VRAM_WR, ch, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            else if (color != 0 && !pwritten[pi])
                send_item(FUNC_PAL_WR, {8'($urandom), pi}, 16'($urandom),
                          8'($urandom), 8'($urandom), 1'b0);
            else
                ready = 1'b1;
        end
        send_item(FUNC_RENDER, addr, wdata, scanline, xpos, 1'b0);
    endtask

    // result side: stall patterns, one long hold-off, in-order check
    int stall_mode, mode_left, hold_left;

    always @(posedge i_clk) begin
        pixel_t got, exp_px;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[15:1], m_axis_tdata[17:16]};
            if (pixel_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("%0t: pixel with none pending, got vis=%0b rgb=%h prio=%0d",
                             $time, got.visible, got.rgb, got.prio);
            end else begin
                exp_px = pixel_q.pop_front();
                n_checked++;
                if (got.visible)
                    n_visible++;
                if (got.visible !== exp_px.visible || got.rgb !== exp_px.rgb ||
                    got.prio !== exp_px.prio) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("%0t: pixel mismatch, expected vis=%0b rgb=%h prio=%0d, got vis=%0b rgb=%h prio=%0d",
                                 $time, exp_px.visible, exp_px.rgb, exp_px.prio,
                                 got.visible, got.rgb, got.prio);
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout at %0t with %0d pixels pending", $time, pixel_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        cfg_set_t dir_cfg [3];
        cfg_set_t cfg;
        int       pick, base, lb, xb;
        logic [7:0] sl, xp;

        dir_cfg[0] = make_cfg(0, 0, 0, 0, 0, 0, 0, 0);
        // every bit set, each register masks to its own maximum
        dir_cfg[1] = make_cfg(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
        dir_cfg[2] = make_cfg(1, 0, 0, 0, 0, 1, 1, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: blank rows are layer off or past the right edge
        for (int i = 0; i < N_DIR; i++) begin
            if (i == 0 || dir_rows[i].preset != dir_rows[i-1].preset) begin
                drain_pipe();
                apply_cfg(dir_cfg[dir_rows[i].preset]);
            end
            if (dir_rows[i].func == FUNC_RENDER && !dir_rows[i].blank)
                render_req(dir_rows[i].scanline, dir_rows[i].xpos,
                           dir_rows[i].addr, dir_rows[i].wdata);
            else
                send_item(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].wdata,
                          dir_rows[i].scanline, dir_rows[i].xpos, dir_rows[i].blank);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_pipe();
            for (int k = 0; k < 8; k++)
                cfg[k] = 9'($urandom_range(0, 511));
            cfg[CFG_LAYER_ENABLE][0] = 1'b1;
            case (ph)
                1: cfg = make_cfg(1, 0, 0, 0, 0, 0, 0, 0);
                2: cfg = make_cfg(1, 511, 511, 31, 3, 3, 1, 3);
                3: cfg[CFG_LAYER_ENABLE][0] = 1'b0;
                default: ;
            endcase
            apply_cfg(cfg);
            if (ph == 0) begin
                hold_req   = 1'b1;
                burst_left = 250;
            end
            lb   = $urandom_range(0, 255);
            xb   = $urandom_range(0, 191);
            base = n_req;
            while (n_req - base < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    if ($urandom_range(0, 9) < 6) begin
                        sl = 8'(lb + $urandom_range(0, 15));
                        xp = 8'(xb + $urandom_range(0, 47));
                    end else begin
                        sl = 8'($urandom);
                        xp = 8'($urandom_range(0, SCREEN_W - 1));
                    end
                    render_req(sl, xp, 16'($urandom), 16'($urandom));
                end else if (pick < 80) begin
                    send_item(FUNC_VRAM_WR, 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 90) begin
                    send_item(FUNC_PAL_WR, 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 1'b0);
                end else if (pick < 94) begin
                    send_item(FUNC_IGNORED, 16'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 1'b0);
                end else begin
                    render_req(8'($urandom), 8'($urandom_range(SCREEN_W, 255)),
                               16'($urandom), 16'($urandom));
                end
            end
        end

        drain_pipe();
        $display("ran %0d render, %0d video write and %0d palette write requests under %0d register settings",
                 n_render, n_vram_wr, n_pal_wr, n_settings);
        $display("compared %0d pixels, %0d opaque, %0d errors", n_checked, n_visible, n_err);
        if (n_err == 0 && pixel_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
